// ===== rtl/rdc_pkg.sv =====
package rdc_pkg;

    localparam int INT_BITS_DEF        = 16;
    localparam int FRAC_BITS_DEF       = 32;
    localparam int MAX_FRAC_DIGITS_DEF = 32;

    localparam int BASE_W  = 10;
    localparam int FDIG_W  = 6;
    localparam int KIND_W  = 3;
    localparam int CHAR_W  = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [BASE_W-1:0] BASE_RESET  = 10'd10;
    localparam logic [FDIG_W-1:0] FDIG_RESET  = 6'd6;
    localparam logic [BASE_W-1:0] BASE_MIN    = 10'd2;
    localparam logic [BASE_W-1:0] BASE_NUMERIC = 10'd62;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_DIGITS = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_MINUS = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POINT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FRAC  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_MINUS     = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_POINT     = 7'd46;
    localparam logic [CHAR_W-1:0] CHAR_SEMICOLON = 7'd59;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BASE_W-1:0] digit_value;
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_result;

    // 0-9, A-Z, a-z; numeric-only bases carry no symbol
    function automatic logic [CHAR_W-1:0] symbol_of(input logic [BASE_W-1:0] d,
                                                    input logic numeric_only);
        logic [BASE_W-1:0] s;
        if (d < 10'd10) begin
            s = d + 10'd48;
        end else if (d <= 10'd35) begin
            s = d + 10'd55;
        end else begin
            s = d + 10'd61;
        end
        return numeric_only ? '0 : s[CHAR_W-1:0];
    endfunction

endpackage

// ===== rtl/rdc_if.sv =====
interface rdc_in_if import rdc_pkg::*; #(
    parameter int INT_BITS  = INT_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 negative;
    logic [INT_BITS-1:0]  int_magnitude;
    logic [FRAC_BITS-1:0] fraction;

    modport source (output valid, negative, int_magnitude, fraction, input ready);
    modport sink   (input valid, negative, int_magnitude, fraction, output ready);
endinterface

interface rdc_out_if import rdc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BASE_W-1:0] digit_value;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, kind, digit_value, char_code, last, input ready);
    modport sink   (input valid, kind, digit_value, char_code, last, output ready);
endinterface

interface rdc_cfg_if import rdc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/radix_digit_converter_top.sv =====
// Radix digit converter: sign, integer digits, point, fraction digits.
// Integer digits come from the bit-serial divider, lowest first, and are sent highest
// first; fraction digits come from a multiply by the base. A new item is accepted only
// in idle, once the last word of the previous item, or its error word, has been sent.
// Reset: synchronous active-low; base returns to 10, frac_digits to 6.
module radix_digit_converter_top import rdc_pkg::*; #(
    parameter int INT_BITS        = INT_BITS_DEF,
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rdc_in_if.sink    i_in,
    rdc_out_if.source o_out,
    rdc_cfg_if.sink   i_cfg
);
    localparam int IW  = $clog2(INT_BITS);
    localparam int CW  = $clog2(INT_BITS + 1);
    localparam int FCW = $clog2(MAX_FRAC_DIGITS + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ERR    = 3'd1;
    localparam logic [2:0] S_SIGN   = 3'd2;
    localparam logic [2:0] S_DIVCHK = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_POP    = 3'd5;
    localparam logic [2:0] S_POINT  = 3'd6;
    localparam logic [2:0] S_FEMIT  = 3'd7;
    // fraction multiply is issued from S_POINT / S_FEMIT via mul_en

    logic [2:0]           r_state;
    logic [BASE_W-1:0]    r_base;
    logic [FDIG_W-1:0]    r_fdig;
    logic                 r_neg;
    logic                 r_nz;
    logic [INT_BITS-1:0]  r_int;
    logic [FRAC_BITS-1:0] r_frac;
    logic [CW-1:0]        r_cnt;
    logic [FCW-1:0]       r_nfrac;
    logic [FCW-1:0]       r_fcnt;
    logic [BASE_W-1:0]    r_stack [INT_BITS];
    logic                 r_out_valid;
    t_result              r_out;

    logic                        in_acc;
    logic                        can_emit;
    logic                        emit_en;
    t_result                     emit_res;
    logic                        numeric_only;
    logic [CW-1:0]               cnt_m1;
    logic [BASE_W-1:0]           pop_digit;
    logic [FCW:0]                fcnt_p1;
    logic                        frac_last;
    logic [FCW-1:0]              nfrac_clamp;
    logic                        div_start;
    logic                        div_done;
    logic [INT_BITS-1:0]         div_quo;
    logic [BASE_W-1:0]           div_rem;
    logic                        mul_en;
    logic [FRAC_BITS+BASE_W-1:0] prod;
    logic [BASE_W-1:0]           frac_digit;

    // config writes land only while idle; a pending write holds off the next item
    assign i_cfg.ready = (r_state == S_IDLE);
    assign i_in.ready  = (r_state == S_IDLE) && !i_cfg.valid;
    assign in_acc      = i_in.valid && i_in.ready;

    // output register parts the sequencer from the sink
    assign can_emit     = !r_out_valid || o_out.ready;
    assign numeric_only = r_base >= BASE_NUMERIC;

    assign cnt_m1     = r_cnt - CW'(1);
    assign pop_digit  = r_stack[cnt_m1[IW-1:0]];
    assign frac_digit = prod[FRAC_BITS +: BASE_W];
    assign fcnt_p1    = {1'b0, r_fcnt} + (FCW+1)'(1);
    assign frac_last  = fcnt_p1 == {1'b0, r_nfrac};

    // frac_digits above the limit clamp to the limit
    always_comb begin
        if ({1'b0, r_fdig} > (FDIG_W+1)'(MAX_FRAC_DIGITS)) begin
            nfrac_clamp = FCW'(MAX_FRAC_DIGITS);
        end else begin
            nfrac_clamp = FCW'(r_fdig);
        end
    end

    assign div_start = (r_state == S_DIVCHK) && (r_int != '0);

    // next multiply goes out as the point or the previous digit leaves
    assign mul_en = emit_en && (((r_state == S_POINT) && (r_nfrac != '0)) ||
                                ((r_state == S_FEMIT) && !frac_last));

    always_comb begin
        emit_en  = 1'b0;
        emit_res = '0;
        case (r_state)
            S_ERR: begin
                emit_en       = can_emit;
                emit_res.kind = KIND_ERROR;
                emit_res.last = 1'b1;
            end
            S_SIGN: begin
                emit_en            = can_emit && r_neg && r_nz;
                emit_res.kind      = KIND_MINUS;
                emit_res.char_code = CHAR_MINUS;
            end
            S_POP: begin
                emit_en              = can_emit && (r_cnt != '0);
                emit_res.kind        = KIND_INT;
                emit_res.digit_value = pop_digit;
                emit_res.char_code   = symbol_of(pop_digit, numeric_only);
            end
            S_POINT: begin
                emit_en            = can_emit;
                emit_res.kind      = KIND_POINT;
                emit_res.char_code = numeric_only ? CHAR_SEMICOLON : CHAR_POINT;
                emit_res.last      = (r_nfrac == '0);
            end
            S_FEMIT: begin
                emit_en              = can_emit;
                emit_res.kind        = KIND_FRAC;
                emit_res.digit_value = frac_digit;
                emit_res.char_code   = symbol_of(frac_digit, numeric_only);
                emit_res.last        = frac_last;
            end
            default: begin
                emit_en  = 1'b0;
                emit_res = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= BASE_RESET;
            r_fdig      <= FDIG_RESET;
            r_cnt       <= '0;
            r_fcnt      <= '0;
            r_nfrac     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_BASE:        r_base <= i_cfg.data;
                    REG_FRAC_DIGITS: r_fdig <= i_cfg.data[FDIG_W-1:0];
                    default:         r_base <= r_base;
                endcase
            end

            if (emit_en) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= (r_base < BASE_MIN) ? S_ERR : S_SIGN;
                        r_cnt   <= '0;
                        r_fcnt  <= '0;
                        r_nfrac <= nfrac_clamp;
                    end
                end
                S_ERR: begin
                    if (emit_en) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SIGN: begin
                    // negative zero prints no sign
                    if (emit_en || !(r_neg && r_nz)) begin
                        r_state <= S_DIVCHK;
                    end
                end
                S_DIVCHK: begin
                    r_state <= (r_int == '0) ? S_POP : S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_DIVCHK;
                    end
                end
                S_POP: begin
                    if (r_cnt == '0) begin
                        r_state <= S_POINT;
                    end else if (emit_en) begin
                        r_cnt <= cnt_m1;
                    end
                end
                S_POINT: begin
                    if (emit_en) begin
                        r_state <= (r_nfrac == '0) ? S_IDLE : S_FEMIT;
                    end
                end
                S_FEMIT: begin
                    if (emit_en) begin
                        r_fcnt  <= fcnt_p1[FCW-1:0];
                        r_state <= frac_last ? S_IDLE : S_FEMIT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_neg  <= i_in.negative;
            r_nz   <= (i_in.int_magnitude != '0) || (i_in.fraction != '0);
            r_int  <= i_in.int_magnitude;
            r_frac <= i_in.fraction;
        end
        if ((r_state == S_DIV) && div_done) begin
            r_stack[r_cnt[IW-1:0]] <= div_rem;
            r_int                  <= div_quo;
        end
        if ((r_state == S_FEMIT) && emit_en) begin
            r_frac <= prod[FRAC_BITS-1:0];
        end
        if (emit_en) begin
            r_out <= emit_res;
        end
    end

    // multiply input: fresh fraction after the point, else the kept remainder
    logic [FRAC_BITS-1:0] mul_frac;
    assign mul_frac = (r_state == S_FEMIT) ? prod[FRAC_BITS-1:0] : r_frac;

    rdc_divider #(
        .INT_BITS (INT_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_int),
        .i_divisor   (r_base),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    rdc_mul_step #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_frac (mul_frac),
        .i_base (r_base),
        .o_prod (prod)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.digit_value = r_out.digit_value;
    assign o_out.char_code   = r_out.char_code;
    assign o_out.last        = r_out.last;
endmodule

// ===== rtl/rdc_divider.sv =====
module rdc_divider import rdc_pkg::*; #(
    parameter int INT_BITS = INT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [INT_BITS-1:0] i_dividend,
    input  logic [BASE_W-1:0]   i_divisor,
    output logic                o_done,
    output logic [INT_BITS-1:0] o_quotient,
    output logic [BASE_W-1:0]   o_remainder
);
    localparam int CW = $clog2(INT_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [INT_BITS-1:0] r_quo;
    logic [BASE_W-1:0]   r_rem;
    logic [BASE_W-1:0]   r_div;

    logic [BASE_W:0] shifted;
    logic            fits;
    logic [BASE_W:0] diff;

    // one restoring step per cycle, quotient bits shift in from the right
    always_comb begin
        shifted = {r_rem, r_quo[INT_BITS-1]};
        fits    = shifted >= {1'b0, r_div};
        diff    = shifted - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(INT_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[INT_BITS-2:0], fits};
            r_rem <= fits ? diff[BASE_W-1:0] : shifted[BASE_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule

// ===== rtl/rdc_mul_step.sv =====
module rdc_mul_step import rdc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [FRAC_BITS-1:0]        i_frac,
    input  logic [BASE_W-1:0]           i_base,
    output logic [FRAC_BITS+BASE_W-1:0] o_prod
);
    logic [FRAC_BITS+BASE_W-1:0] r_prod;

    // digit sits above the binary point, the rest feeds the next step
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {{BASE_W{1'b0}}, i_frac} * {{FRAC_BITS{1'b0}}, i_base};
        end
    end

    assign o_prod = r_prod;
endmodule
